/* rtl/nprf_pkg.sv */
// Package for the Newton polynomial root finder: widths, status codes,
// controller-datapath command and status types. No dependencies.
`timescale 1ns / 1ps
package nprf_pkg;
	localparam int MAX_DEGREE = 5;
	localparam int MAX_STEPS  = 64;
	localparam int NUM_COEF   = 6;
	localparam int STEP_W     = 7;
	localparam int DEG_W      = 3;
	localparam int CFG_IDX_W  = 3;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_BAD_BOUND = 2'd1;
	localparam logic [1:0] ST_LIMIT     = 2'd2;
	localparam logic [1:0] ST_ZERO_DER  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF0   = 3'd2;

	typedef enum logic [2:0] {
		OP_EVAL_P = 3'b001,
		OP_EVAL_D = 3'b010,
		OP_DIV    = 3'b100
	} op_t;

	typedef enum logic [1:0] {
		X_LEFT  = 2'b01,
		X_RIGHT = 2'b10
	} xsel_t;

	typedef struct packed {
		logic  start;
		op_t   op;
		xsel_t xsel;
		logic  load;
		logic  upd_left;
		logic  upd_right;
	} dp_cmd_t;

	typedef struct packed {
		logic        done;
		logic signed [31:0] value;
		logic signed [31:0] x;
		logic        below_eps;
		logic        bounds_ok;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

/* rtl/newton_polynomial_root_finder_unit.sv */
// Channel  | signals                              | dir
// input    | in_valid in_stall left_bound right_bound | in
// output   | out_valid out_stall root step_count status | out
// config   | cfg_valid cfg_ready cfg_index cfg_data | in
// An item is quickest with bad bounds at degree one and longest at degree five
// with 64 steps and zero slope at left every step: a step runs up to
// four Horner passes (a multiply and an add a term on one 32x32 multiplier)
// and a pass through the 48-bit restoring divider.
// One item at a time; input stalls while busy and while the result waits.
// Reset is asynchronous, active low; result holds while out_stall is high.
`timescale 1ns / 1ps
module newton_polynomial_root_finder_unit import nprf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] left_bound,
	input  logic signed [31:0] right_bound,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] root,
	output logic [STEP_W-1:0] step_count,
	output logic [1:0] status
);
	logic [DEG_W-1:0] degree_q, deg_eff;
	logic [30:0] epsilon_q;
	logic signed [31:0] coef_q [NUM_COEF];
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;
	always_comb begin
		if (degree_q == 0) deg_eff = 3'd1;
		else if (degree_q > 3'(MAX_DEGREE)) deg_eff = 3'(MAX_DEGREE);
		else deg_eff = degree_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q  <= 3'd1;
			epsilon_q <= 31'd1;
			for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_DEGREE) degree_q <= cfg_data[2:0];
			else if (cfg_index == REG_EPSILON) epsilon_q <= cfg_data[30:0];
			else coef_q[cfg_index - REG_COEF0] <= cfg_data;
		end
	end

	nprf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .deg_eff(deg_eff), .epsilon(epsilon_q),
		.coef(coef_q), .left_in(left_bound), .right_in(right_bound),
		.cmd(cmd), .sts(sts)
	);

	nprf_controller u_ctl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts),
		.root(root), .step_count(step_count), .status(status)
	);
endmodule

/* rtl/nprf_datapath.sv */
// Datapath: bounds, Horner evaluator on one multiplier, bit-serial divider.
// Depends on nprf_pkg.
`timescale 1ns / 1ps
module nprf_datapath import nprf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [DEG_W-1:0] deg_eff,
	input  logic [30:0] epsilon,
	input  logic signed [31:0] coef [NUM_COEF],
	input  logic signed [31:0] left_in,
	input  logic signed [31:0] right_in,
	input  dp_cmd_t cmd,
	output dp_sts_t sts
);
	typedef enum logic [3:0] {
		U_IDLE = 4'b0001,
		U_MUL  = 4'b0010,
		U_ADD  = 4'b0100,
		U_DIV  = 4'b1000
	} ust_t;

	ust_t ust_q;
	logic signed [31:0] left_q, right_q, x_q, acc_q, pl_q, pr_q, den_q;
	logic signed [63:0] prod_q;
	logic [DEG_W-1:0] idx_q;
	logic der_q, neg_q, done_q;
	logic [5:0] dcnt_q;
	logic [47:0] dvd_q, quo_q;
	logic [31:0] rem_q, dmag_q;

	logic [DEG_W-1:0] tidx;
	logic signed [31:0] cterm, qmul_r, quot, num;
	logic [32:0] trial;
	logic done_set;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(33'd0 - {1'b1, v}) : $unsigned(v);
	endfunction

	function automatic logic signed [31:0] dcoef(input logic [DEG_W-1:0] i,
			input logic signed [31:0] c [NUM_COEF]);
		logic signed [31:0] cv;
		logic signed [65:0] k;
		if (i < DEG_W'(MAX_DEGREE)) cv = c[i + DEG_W'(1)];
		else cv = '0;
		k = 66'(i) + 66'sd1;
		return sat32(66'(cv) * k);
	endfunction

	always_comb begin
		tidx = idx_q - DEG_W'(1);
		if (der_q) cterm = dcoef(tidx, coef);
		else if (tidx < DEG_W'(NUM_COEF)) cterm = coef[tidx];
		else cterm = '0;
		qmul_r = sat32(66'(prod_q >>> 16));
		num = (cmd.xsel == X_LEFT) ? pl_q : pr_q;
		trial = {rem_q, dvd_q[47]};
		quot = sat32(neg_q ? 66'd0 - 66'(quo_q) : 66'(quo_q));
		done_set = (ust_q == U_IDLE && cmd.start && cmd.op == OP_EVAL_D &&
				deg_eff == DEG_W'(1)) ||
			(ust_q == U_ADD && idx_q == DEG_W'(1)) ||
			(ust_q == U_DIV && dcnt_q == 6'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ust_q   <= U_IDLE;
			done_q  <= 1'b0;
			left_q  <= '0;
			right_q <= '0;
			x_q     <= '0;
			acc_q   <= '0;
			pl_q    <= '0;
			pr_q    <= '0;
			den_q   <= '0;
			prod_q  <= '0;
			idx_q   <= '0;
			der_q   <= 1'b0;
			neg_q   <= 1'b0;
			dcnt_q  <= '0;
			dvd_q   <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			dmag_q  <= '0;
		end else begin
			done_q <= done_set;
			if (cmd.load) begin
				left_q  <= left_in;
				right_q <= right_in;
			end else if (cmd.upd_left) begin
				left_q <= sat32(66'(left_q) - 66'(quot));
			end else if (cmd.upd_right) begin
				right_q <= sat32(66'(right_q) - 66'(quot));
			end
			if (done_q && cmd.op == OP_EVAL_P) begin
				if (cmd.xsel == X_LEFT) pl_q <= acc_q;
				else pr_q <= acc_q;
			end else if (done_q && cmd.op == OP_EVAL_D) begin
				den_q <= acc_q;
			end
			unique case (ust_q)
				U_IDLE: if (cmd.start) begin
					x_q <= (cmd.xsel == X_LEFT) ? left_q : right_q;
					if (cmd.op == OP_DIV) begin
						dvd_q  <= {mag32(num), 16'd0};
						dmag_q <= mag32(den_q);
						neg_q  <= num[31] ^ den_q[31];
						rem_q  <= '0;
						quo_q  <= '0;
						dcnt_q <= 6'd48;
						ust_q  <= U_DIV;
					end else if (cmd.op == OP_EVAL_D) begin
						der_q <= 1'b1;
						idx_q <= deg_eff - DEG_W'(1);
						acc_q <= dcoef(deg_eff - DEG_W'(1), coef);
						ust_q <= (deg_eff == DEG_W'(1)) ? U_IDLE : U_MUL;
					end else begin
						der_q <= 1'b0;
						idx_q <= deg_eff;
						acc_q <= coef[deg_eff];
						ust_q <= U_MUL;
					end
				end
				U_MUL: begin
					prod_q <= 64'(acc_q) * 64'(x_q);
					ust_q  <= U_ADD;
				end
				U_ADD: begin
					acc_q <= sat32(66'(qmul_r) + 66'(cterm));
					idx_q <= tidx;
					ust_q <= (idx_q == DEG_W'(1)) ? U_IDLE : U_MUL;
				end
				U_DIV: begin
					dvd_q  <= {dvd_q[46:0], 1'b0};
					dcnt_q <= dcnt_q - 6'd1;
					if (trial >= {1'b0, dmag_q}) begin
						rem_q <= 32'(trial - {1'b0, dmag_q});
						quo_q <= {quo_q[46:0], 1'b1};
					end else begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[46:0], 1'b0};
					end
					if (dcnt_q == 6'd1) ust_q <= U_IDLE;
				end
				default: ust_q <= U_IDLE;
			endcase
		end
	end

	assign sts.done      = done_q;
	assign sts.value     = acc_q;
	assign sts.x         = x_q;
	assign sts.below_eps = {1'b0, mag32(acc_q)} < {2'b0, epsilon};
	assign sts.bounds_ok = left_q < right_q;
endmodule

/* rtl/nprf_controller.sv */
// Step sequencer: bound checks, per-step evaluations, result and handshake.
// Depends on nprf_pkg.
`timescale 1ns / 1ps
module nprf_controller import nprf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output dp_cmd_t cmd,
	input  dp_sts_t sts,
	output logic signed [31:0] root,
	output logic [STEP_W-1:0] step_count,
	output logic [1:0] status
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CHKL  = 10'b0000000010,
		S_CHKR  = 10'b0000000100,
		S_PL    = 10'b0000001000,
		S_PR    = 10'b0000010000,
		S_DL    = 10'b0000100000,
		S_DR    = 10'b0001000000,
		S_DIV   = 10'b0010000000,
		S_UPD   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic busy_q, useleft_q;
	logic [STEP_W-1:0] steps_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.op = OP_EVAL_P;
		cmd.xsel = X_LEFT;
		cmd.load = (state_q == S_IDLE) && in_valid;
		unique case (state_q)
			S_CHKL, S_PL: begin cmd.start = !busy_q; end
			S_CHKR, S_PR: begin cmd.start = !busy_q; cmd.xsel = X_RIGHT; end
			S_DL: begin cmd.start = !busy_q; cmd.op = OP_EVAL_D; end
			S_DR: begin cmd.start = !busy_q; cmd.op = OP_EVAL_D; cmd.xsel = X_RIGHT; end
			S_DIV: begin cmd.start = !busy_q; cmd.op = OP_DIV;
				cmd.xsel = useleft_q ? X_LEFT : X_RIGHT; end
			S_UPD: begin cmd.upd_left = useleft_q; cmd.upd_right = !useleft_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			busy_q     <= 1'b0;
			out_valid  <= 1'b0;
			useleft_q  <= 1'b0;
			steps_q    <= '0;
			root       <= '0;
			step_count <= '0;
			status     <= ST_CONVERGED;
		end else begin
			busy_q <= (busy_q | cmd.start) & ~sts.done;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_CHKL;
					steps_q <= '0;
				end
				S_CHKL: if (sts.done) begin
					if (!sts.bounds_ok || sts.value > 0) begin
						root <= '0; step_count <= '0; status <= ST_BAD_BOUND;
						state_q <= S_OUT; out_valid <= 1'b1;
					end else state_q <= S_CHKR;
				end
				S_CHKR: if (sts.done) begin
					if (sts.value < 0) begin
						root <= '0; step_count <= '0; status <= ST_BAD_BOUND;
						state_q <= S_OUT; out_valid <= 1'b1;
					end else state_q <= S_PL;
				end
				S_PL: if (sts.done) begin
					steps_q <= steps_q + 1'b1;
					if (sts.below_eps) begin
						root <= sts.x; step_count <= steps_q + 1'b1;
						status <= ST_CONVERGED; state_q <= S_OUT; out_valid <= 1'b1;
					end else state_q <= S_PR;
				end
				S_PR: if (sts.done) begin
					if (sts.below_eps) begin
						root <= sts.x; step_count <= steps_q;
						status <= ST_CONVERGED; state_q <= S_OUT; out_valid <= 1'b1;
					end else state_q <= S_DL;
				end
				S_DL: if (sts.done) begin
					if (sts.value != 0) begin
						useleft_q <= 1'b1; state_q <= S_DIV;
					end else state_q <= S_DR;
				end
				S_DR: if (sts.done) begin
					if (sts.value != 0) begin
						useleft_q <= 1'b0; state_q <= S_DIV;
					end else begin
						root <= '0; step_count <= steps_q; status <= ST_ZERO_DER;
						state_q <= S_OUT; out_valid <= 1'b1;
					end
				end
				S_DIV: if (sts.done) state_q <= S_UPD;
				S_UPD: begin
					if (steps_q == STEP_W'(MAX_STEPS)) begin
						root <= '0; step_count <= steps_q; status <= ST_LIMIT;
						state_q <= S_OUT; out_valid <= 1'b1;
					end else state_q <= S_PL;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT)
		else $error("result shown outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD_BOUND |-> step_count == 0)
		else $error("bad bounds with nonzero steps");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> steps_q <= STEP_W'(MAX_STEPS))
		else $error("step counter past limit");
endmodule
